// ----- hw/rtl/bcdclk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdclk_pkg
// Shared types, codes and the seven-segment font of the BCD clock display core.
// ----------------------------------------------------------------------------
package bcdclk_pkg;

	// Command codes carried on cmd
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_SCAN  = 2'd2;

	// Time byte indexes carried on byte_index
	localparam logic [2:0] IDX_SECONDS = 3'd0;
	localparam logic [2:0] IDX_MINUTES = 3'd1;
	localparam logic [2:0] IDX_HOURS   = 3'd2;
	localparam logic [2:0] IDX_COMMIT  = 3'd7;

	// Clock limits
	localparam logic [7:0] SEC_MAX      = 8'd59;
	localparam logic [7:0] MIN_TENS_MAX = 8'h50;
	localparam logic [7:0] HOUR_MAX     = 8'h23;
	localparam logic [5:0] DOT_MAX      = 6'd61;

	// Digit code that draws a blank digit
	localparam logic [3:0] DIGIT_BLANK = 4'd10;

	// Colon dots (60 and 61) in the flat dot layout: byte 7, bits 3 and 2
	localparam logic [63:0] COLON_MASK = 64'h0C00_0000_0000_0000;

	// Font byte of a digit 0..9, blank for 10 and above
	function automatic logic [7:0] seg_font(input logic [3:0] v);
		logic [7:0] f;
		case (v)
			4'd0:    f = 8'hEE;
			4'd1:    f = 8'h24;
			4'd2:    f = 8'hBA;
			4'd3:    f = 8'hB6;
			4'd4:    f = 8'h74;
			4'd5:    f = 8'hD6;
			4'd6:    f = 8'hDE;
			4'd7:    f = 8'hA4;
			4'd8:    f = 8'hFE;
			4'd9:    f = 8'hF6;
			default: f = 8'h00;
		endcase
		return f;
	endfunction

	// Row select nibble: upper nibble of ((row + 1) << 4) ^ 0xF0
	function automatic logic [3:0] row_select(input logic [2:0] row);
		logic [3:0] r1;
		r1 = {1'b0, row} + 4'd1;
		return r1 ^ 4'hF;
	endfunction

	// One result beat
	typedef struct packed {
		logic [2:0] scan_row;
		logic [7:0] row_pattern;
		logic [7:0] second_dots;
		logic [7:0] seconds_now;
		logic [7:0] minutes_now;
		logic [7:0] hours_now;
	} result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bcd_clock_led_display_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_clock_led_display_core
// BCD clock with a 62-dot seconds ring and four seven-segment digits, scanned
// out one display row per scan beat.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | in_valid / in_stall    | cmd, byte_index, byte_value
//  output  | out_valid / out_stall  | scan_row, row_pattern, second_dots,
//          |                        | seconds_now, minutes_now, hours_now
//
//  The clock, dot and digit state of a beat updates in the cycle it is
//  accepted, and its result is registered at the same edge.
//  Throughput is one beat per cycle while in_stall is low.
//  A two-entry output buffer (result register plus skid register) lets one
//  more beat in while a result is stalled; in_stall rises only when both hold.
//  Reset loads time 00:00:00 with the display drawn for it, dots dark.
// ----------------------------------------------------------------------------
module bcd_clock_led_display_core
	import bcdclk_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [2:0] byte_index,
	input  wire logic [7:0] byte_value,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      scan_row,
	output logic [7:0]      row_pattern,
	output logic [7:0]      second_dots,
	output logic [7:0]      seconds_now,
	output logic [7:0]      minutes_now,
	output logic [7:0]      hours_now
);

	// Clock and display state
	logic        phase_q;
	logic [7:0]  sec_q;
	logic [7:0]  min_q;
	logic [7:0]  hour_q;
	logic [63:0] dot_q;
	logic [7:0]  seg_q [4];
	logic [2:0]  row_q;

	// Next state
	logic        phase_n;
	logic [7:0]  sec_n;
	logic [7:0]  min_n;
	logic [7:0]  hour_n;
	logic [63:0] dot_n;
	logic [7:0]  seg_n [4];
	logic [2:0]  row_n;

	// Output buffer
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	result_t res;

	logic in_fire;
	logic out_fire;

	// Flat bit position of a dot: odd bytes are bit-reversed
	function automatic logic [5:0] dot_pos(input logic [5:0] s);
		return {s[5:3], s[3] ? ~s[2:0] : s[2:0]};
	endfunction

	// Redraw a digit only for codes 0..10
	function automatic logic [7:0] put_digit(input logic [7:0] old, input logic [3:0] v);
		return (v <= DIGIT_BLANK) ? seg_font(v) : old;
	endfunction

	// Hours tens digit: blank below ten
	function automatic logic [3:0] hour_tens(input logic [7:0] h);
		return (h < 8'd10) ? DIGIT_BLANK : h[7:4];
	endfunction

	assign in_fire  = in_valid && !skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;
	assign in_stall = skid_valid_q;

	// Work out the state after one beat
	always_comb begin
		logic [63:0] set_m;
		logic [63:0] clr_m;
		logic [7:0]  s1;
		logic [5:0]  nxt_dot;
		logic [7:0]  m1;
		logic [7:0]  m2;
		logic [7:0]  h1;
		logic [7:0]  h2;
		logic [7:0]  h3;
		logic        mcarry;
		logic        tcarry;

		phase_n = phase_q;
		sec_n   = sec_q;
		min_n   = min_q;
		hour_n  = hour_q;
		dot_n   = dot_q;
		seg_n   = seg_q;
		row_n   = row_q;
		set_m   = '0;
		clr_m   = '0;

		s1      = sec_q + 8'd1;
		nxt_dot = (sec_q < SEC_MAX) ? s1[5:0] : 6'd0;

		// Minute and hour carries
		m1     = min_q + 8'd1;
		mcarry = (m1[3:0] > 4'd9);
		m2     = (m1 + 8'h10) & 8'hF0;
		tcarry = mcarry && (m2 > MIN_TENS_MAX);
		h1     = hour_q + 8'd1;
		h2     = (h1[3:0] > 4'd9) ? ((h1 & 8'h30) + 8'h10) : h1;
		h3     = (h2 > HOUR_MAX) ? 8'd0 : h2;

		case (cmd)
			CMD_TICK: begin
				if (!phase_q) begin
					// First half: light the next dot, drop the colon
					phase_n = 1'b1;
					set_m[dot_pos(nxt_dot)] = 1'b1;
					clr_m = COLON_MASK;
					dot_n = (dot_q | set_m) & ~clr_m;
				end else begin
					// Second half: drop the current dot, light the colon, advance
					phase_n = 1'b0;
					if (sec_q <= {2'b00, DOT_MAX})
						clr_m[dot_pos(sec_q[5:0])] = 1'b1;
					dot_n = (dot_q & ~clr_m) | COLON_MASK;
					sec_n = s1;
					if (s1 > SEC_MAX) begin
						sec_n = 8'd0;
						if (tcarry) begin
							min_n    = 8'd0;
							hour_n   = h3;
							seg_n[2] = put_digit(seg_q[2], h3[3:0]);
							seg_n[3] = put_digit(seg_q[3], hour_tens(h3));
						end else if (mcarry) begin
							min_n = m2;
						end else begin
							min_n = m1;
						end
						if (mcarry)
							seg_n[1] = put_digit(seg_q[1], min_n[7:4]);
						seg_n[0] = put_digit(seg_q[0], min_n[3:0]);
					end
				end
			end
			CMD_WRITE: begin
				case (byte_index)
					IDX_SECONDS: sec_n = byte_value;
					IDX_MINUTES: min_n = byte_value;
					IDX_HOURS:   hour_n = byte_value;
					IDX_COMMIT: begin
						// Refresh: clear the ring and digit nibbles, redraw all four digits
						dot_n    = '0;
						seg_n[0] = put_digit(8'h00, min_q[3:0]);
						seg_n[1] = put_digit(8'h00, min_q[7:4]);
						seg_n[2] = put_digit(8'h00, hour_q[3:0]);
						seg_n[3] = put_digit(8'h00, hour_tens(hour_q));
					end
					default: ;
				endcase
			end
			CMD_SCAN: row_n = row_q + 3'd1;
			default: ;
		endcase
	end

	// Result of the beat from the new state
	always_comb begin
		logic [7:0] seg;
		seg = seg_n[row_n[2:1]];
		res.scan_row    = row_n;
		res.row_pattern = {row_select(row_n), row_n[0] ? seg[7:4] : seg[3:0]};
		res.second_dots = dot_n[{row_n, 3'b000} +: 8];
		res.seconds_now = sec_n;
		res.minutes_now = min_n;
		res.hours_now   = hour_n;
	end

	// Hold the clock and display state, advance on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			sec_q    <= '0;
			min_q    <= '0;
			hour_q   <= '0;
			dot_q    <= '0;
			seg_q[0] <= seg_font(4'd0);
			seg_q[1] <= seg_font(4'd0);
			seg_q[2] <= seg_font(4'd0);
			seg_q[3] <= seg_font(DIGIT_BLANK);
			row_q    <= '0;
		end else if (in_fire) begin
			phase_q <= phase_n;
			sec_q   <= sec_n;
			min_q   <= min_n;
			hour_q  <= hour_n;
			dot_q   <= dot_n;
			seg_q   <= seg_n;
			row_q   <= row_n;
		end
	end

	// Output register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_fire) begin
			out_valid_q  <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_fire) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign scan_row    = out_q.scan_row;
	assign row_pattern = out_q.row_pattern;
	assign second_dots = out_q.second_dots;
	assign seconds_now = out_q.seconds_now;
	assign minutes_now = out_q.minutes_now;
	assign hours_now   = out_q.hours_now;

	// A skid beat only waits behind a presented result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a beat with no result presented");

	// After an accepted beat the output always presents a result in the next cycle
	a_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted beat produced no result");

	// A scan beat moves the row by one
	a_scan_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_SCAN) |=> (row_q == $past(row_q) + 3'd1))
		else $error("scan beat did not advance the row");

	// The second half-tick lights both colon dots
	a_colon_on: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_TICK && phase_q) |=>
		((dot_q & COLON_MASK) == COLON_MASK) && !phase_q)
		else $error("colon not lit after second half-tick");

	// The first half-tick darkens the colon
	a_colon_off: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_TICK && !phase_q) |=>
		((dot_q & COLON_MASK) == 64'd0) && phase_q)
		else $error("colon still lit after first half-tick");

endmodule
`default_nettype wire
